// ----- src/ots_pkg.sv -----
// Shared types and constants for the overcurrent trip supervisor.
`default_nettype none

package ots_pkg;

    localparam int CUR_W     = 19;
    localparam int MA_W      = 18;
    localparam int CH_IN_W   = 8;
    localparam int TCH_W     = 3;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam logic [MA_W-1:0] MAX_VALID_MA = 18'd200000;
    localparam logic [MA_W-1:0] LEVEL_RESET  = 18'd262143;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CHAN_ON = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 2'd3;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_WARNING  = 2'd1,
        MODE_CRITICAL = 2'd2,
        MODE_LOCKOUT  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode mode;
        logic  allow_switch;
    } t_ctrl;

    typedef struct packed {
        t_mode              mode;
        logic               accepted;
        logic               switch_permit;
        logic               turn_on_allowed;
        logic               trip_fired;
        logic               trip_all;
        logic [TCH_W-1:0]   trip_channel;
        logic [CNT_W-1:0]   trips_total;
        logic [TIME_W-1:0]  last_trip_ms;
        logic [MA_W-1:0]    latest_ma;
    } t_result;

endpackage

`default_nettype wire

// ----- src/overcurrent_trip_supervisor_core.sv -----
// Overcurrent trip supervisor top level: registers, handshakes and configuration.
// Throughput: one item per cycle while the output is not stalled (i_out_ready low).
// Path: input register, one evaluation stage, result register.
// State is updated as each result is registered, so back-to-back items see it at once.
// Reset (synchronous, active low) restores levels, mode, counters and channel record.
`default_nettype none

module overcurrent_trip_supervisor_core #(
    parameter int NUM_CHANNELS = ots_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ots_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ots_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_op,
    input  wire logic signed [ots_pkg::CUR_W-1:0]  i_current_ma,
    input  wire logic [ots_pkg::CH_IN_W-1:0]       i_channel,
    input  wire logic [ots_pkg::TIME_W-1:0]        i_time_ms,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_mode,
    output logic                                   o_accepted,
    output logic                                   o_switch_permit,
    output logic                                   o_turn_on_allowed,
    output logic                                   o_trip_fired,
    output logic                                   o_trip_all,
    output logic [ots_pkg::TCH_W-1:0]              o_trip_channel,
    output logic [ots_pkg::CNT_W-1:0]              o_trips_total,
    output logic [ots_pkg::TIME_W-1:0]             o_last_trip_ms,
    output logic [ots_pkg::MA_W-1:0]               o_latest_ma
);

    localparam int CH_W = $clog2(NUM_CHANNELS + 1);

    logic                        r_enable;
    logic [ots_pkg::MA_W-1:0]    r_warn;
    logic [ots_pkg::MA_W-1:0]    r_crit;
    logic [ots_pkg::MA_W-1:0]    r_recover;

    ots_pkg::t_ctrl              r_ctrl;
    logic [CH_W-1:0]             r_chan;
    logic [ots_pkg::CNT_W-1:0]   r_count;
    logic [ots_pkg::TIME_W-1:0]  r_stamp;
    logic [ots_pkg::MA_W-1:0]    r_sample;

    logic                        r_in_valid;
    logic [1:0]                  r_op;
    logic [ots_pkg::CUR_W-1:0]   r_cur;
    logic [ots_pkg::CH_IN_W-1:0] r_ch;
    logic [ots_pkg::TIME_W-1:0]  r_time;

    logic                        r_out_valid;
    ots_pkg::t_result            r_res;

    ots_pkg::t_ctrl              n_ctrl;
    logic [CH_W-1:0]             n_chan;
    logic [ots_pkg::CNT_W-1:0]   n_count;
    logic [ots_pkg::TIME_W-1:0]  n_stamp;
    logic [ots_pkg::MA_W-1:0]    n_sample;
    ots_pkg::t_result            n_res;

    logic                        w_adv;
    logic                        w_fire;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_adv;
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_warn    <= ots_pkg::LEVEL_RESET;
            r_crit    <= ots_pkg::LEVEL_RESET;
            r_recover <= ots_pkg::LEVEL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ots_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                ots_pkg::CFG_WARN:    r_warn    <= i_cfg_data;
                ots_pkg::CFG_CRIT:    r_crit    <= i_cfg_data;
                ots_pkg::CFG_RECOVER: r_recover <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_cur  <= i_current_ma;
            r_ch   <= i_channel;
            r_time <= i_time_ms;
        end
    end

    ots_step #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_W         (CH_W)
    ) u_step (
        .i_enable     (r_enable),
        .i_warn       (r_warn),
        .i_crit       (r_crit),
        .i_recover    (r_recover),
        .i_op         (r_op),
        .i_current_ma (r_cur),
        .i_channel    (r_ch),
        .i_time_ms    (r_time),
        .i_ctrl       (r_ctrl),
        .i_chan       (r_chan),
        .i_count      (r_count),
        .i_stamp      (r_stamp),
        .i_sample     (r_sample),
        .o_ctrl       (n_ctrl),
        .o_chan       (n_chan),
        .o_count      (n_count),
        .o_stamp      (n_stamp),
        .o_sample     (n_sample),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '{mode: ots_pkg::MODE_NORMAL, allow_switch: 1'b1};
            r_chan   <= CH_W'(NUM_CHANNELS);
            r_count  <= '0;
            r_stamp  <= '0;
            r_sample <= '0;
        end else if (w_fire) begin
            r_ctrl   <= n_ctrl;
            r_chan   <= n_chan;
            r_count  <= n_count;
            r_stamp  <= n_stamp;
            r_sample <= n_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mode            = r_res.mode;
    assign o_accepted        = r_res.accepted;
    assign o_switch_permit   = r_res.switch_permit;
    assign o_turn_on_allowed = r_res.turn_on_allowed;
    assign o_trip_fired      = r_res.trip_fired;
    assign o_trip_all        = r_res.trip_all;
    assign o_trip_channel    = r_res.trip_channel;
    assign o_trips_total     = r_res.trips_total;
    assign o_last_trip_ms    = r_res.last_trip_ms;
    assign o_latest_ma       = r_res.latest_ma;

endmodule

`default_nettype wire

// ----- src/ots_step.sv -----
// Per-item evaluation: next protection state and the result for one transfer.
`default_nettype none

module ots_step #(
    parameter int NUM_CHANNELS = ots_pkg::NUM_CHANNELS_DEF,
    parameter int CH_W         = $clog2(NUM_CHANNELS + 1)
) (
    input  wire logic                          i_enable,
    input  wire logic [ots_pkg::MA_W-1:0]      i_warn,
    input  wire logic [ots_pkg::MA_W-1:0]      i_crit,
    input  wire logic [ots_pkg::MA_W-1:0]      i_recover,
    input  wire logic [1:0]                    i_op,
    input  wire logic [ots_pkg::CUR_W-1:0]     i_current_ma,
    input  wire logic [ots_pkg::CH_IN_W-1:0]   i_channel,
    input  wire logic [ots_pkg::TIME_W-1:0]    i_time_ms,
    input  wire ots_pkg::t_ctrl                i_ctrl,
    input  wire logic [CH_W-1:0]               i_chan,
    input  wire logic [ots_pkg::CNT_W-1:0]     i_count,
    input  wire logic [ots_pkg::TIME_W-1:0]    i_stamp,
    input  wire logic [ots_pkg::MA_W-1:0]      i_sample,
    output ots_pkg::t_ctrl                     o_ctrl,
    output logic [CH_W-1:0]                    o_chan,
    output logic [ots_pkg::CNT_W-1:0]          o_count,
    output logic [ots_pkg::TIME_W-1:0]         o_stamp,
    output logic [ots_pkg::MA_W-1:0]           o_sample,
    output ots_pkg::t_result                   o_res
);

    logic [ots_pkg::MA_W-1:0]  w_ma;
    logic                      w_valid_sample;
    logic                      w_accepted;
    logic                      w_fired;
    logic                      w_all;
    logic [ots_pkg::TCH_W-1:0] w_tch;

    assign w_ma           = i_current_ma[ots_pkg::MA_W-1:0];
    assign w_valid_sample = i_enable && !i_current_ma[ots_pkg::CUR_W-1]
                            && (w_ma <= ots_pkg::MAX_VALID_MA);

    always_comb begin
        o_ctrl     = i_ctrl;
        o_chan     = i_chan;
        o_count    = i_count;
        o_stamp    = i_stamp;
        o_sample   = i_sample;
        w_accepted = 1'b0;
        w_fired    = 1'b0;
        w_all      = 1'b0;
        w_tch      = '0;
        unique case (i_op)
            ots_pkg::OP_SAMPLE: begin
                if (w_valid_sample) begin
                    w_accepted = 1'b1;
                    o_sample   = w_ma;
                    unique case (i_ctrl.mode)
                        ots_pkg::MODE_NORMAL, ots_pkg::MODE_WARNING: begin
                            if (w_ma >= i_crit) begin
                                o_ctrl.mode = ots_pkg::MODE_CRITICAL;
                            end else if (w_ma >= i_warn) begin
                                o_ctrl.mode = ots_pkg::MODE_WARNING;
                            end else begin
                                o_ctrl.mode = ots_pkg::MODE_NORMAL;
                            end
                        end
                        ots_pkg::MODE_CRITICAL: begin
                            o_ctrl.mode         = ots_pkg::MODE_LOCKOUT;
                            o_ctrl.allow_switch = 1'b0;
                            o_count             = i_count + ots_pkg::CNT_W'(1);
                            o_stamp             = i_time_ms;
                            w_fired             = 1'b1;
                            if (i_chan < CH_W'(NUM_CHANNELS)) begin
                                w_tch = ots_pkg::TCH_W'(i_chan);
                            end else begin
                                w_all = 1'b1;
                            end
                        end
                        ots_pkg::MODE_LOCKOUT: begin
                            if (w_ma < i_recover) begin
                                o_ctrl.mode         = ots_pkg::MODE_NORMAL;
                                o_ctrl.allow_switch = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ots_pkg::OP_CHAN_ON: begin
                if (i_channel < ots_pkg::CH_IN_W'(NUM_CHANNELS)) begin
                    o_chan = CH_W'(i_channel);
                end
            end
            ots_pkg::OP_CLEAR: begin
                if (i_ctrl.mode == ots_pkg::MODE_LOCKOUT) begin
                    o_ctrl.mode         = ots_pkg::MODE_NORMAL;
                    o_ctrl.allow_switch = 1'b1;
                    w_accepted          = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (i_enable) begin
            o_res.mode            = o_ctrl.mode;
            o_res.switch_permit   = o_ctrl.allow_switch;
            o_res.turn_on_allowed = o_ctrl.allow_switch
                                    && (o_ctrl.mode == ots_pkg::MODE_NORMAL);
        end else begin
            o_res.mode            = ots_pkg::MODE_NORMAL;
            o_res.switch_permit   = 1'b1;
            o_res.turn_on_allowed = 1'b1;
        end
        o_res.accepted     = w_accepted;
        o_res.trip_fired   = w_fired;
        o_res.trip_all     = w_all;
        o_res.trip_channel = w_tch;
        o_res.trips_total  = o_count;
        o_res.last_trip_ms = o_stamp;
        o_res.latest_ma    = o_sample;
    end

endmodule

`default_nettype wire

// ----- src/ots_checker.sv -----
// Port-level checks for the overcurrent trip supervisor, bound to the top level.
`default_nettype none

module ots_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [1:0]                   o_mode,
    input wire logic                         o_switch_permit,
    input wire logic                         o_turn_on_allowed,
    input wire logic                         o_trip_fired,
    input wire logic                         o_trip_all,
    input wire logic [ots_pkg::TCH_W-1:0]    o_trip_channel,
    input wire logic [ots_pkg::CNT_W-1:0]    o_trips_total
);

    a_trip_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_trip_fired |->
            o_mode == ots_pkg::MODE_LOCKOUT && !o_switch_permit && !o_turn_on_allowed)
        else $error("trip transfer without lockout status");

    a_no_trip_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_trip_fired |-> !o_trip_all && o_trip_channel == '0)
        else $error("trip target shown without a trip");

    a_turn_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_turn_on_allowed |->
            o_switch_permit && o_mode == ots_pkg::MODE_NORMAL)
        else $error("turn-on allowed outside normal switching");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_trips_total) && $stable(o_mode))
        else $error("stalled result changed");

endmodule

bind overcurrent_trip_supervisor_core ots_checker u_ots_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_mode            (o_mode),
    .o_switch_permit   (o_switch_permit),
    .o_turn_on_allowed (o_turn_on_allowed),
    .o_trip_fired      (o_trip_fired),
    .o_trip_all        (o_trip_all),
    .o_trip_channel    (o_trip_channel),
    .o_trips_total     (o_trips_total)
);

`default_nettype wire
